/* rtl/bbap_pkg.sv */
// Shared types and constants for the advertising beacon parser.
// No dependencies; used by every module of the block.
package bbap_pkg;

    localparam int OUT_ID_BYTES = 20;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_APL  = 3'd1,
        KIND_ALT  = 3'd2,
        KIND_UID  = 3'd3,
        KIND_URL  = 3'd4,
        KIND_TLM  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PATH_DEAD = 2'd0,
        PATH_MFR  = 2'd1,
        PATH_SVC  = 2'd2
    } path_t;

    localparam logic [7:0] AD_TYPE_MFR   = 8'hff;
    localparam logic [7:0] AD_TYPE_SVC   = 8'h16;
    localparam logic [7:0] CO_APL_LO     = 8'h4c;
    localparam logic [7:0] APL_PFX_0     = 8'h02;
    localparam logic [7:0] APL_PFX_1     = 8'h15;
    localparam logic [7:0] ALT_PFX_0     = 8'hbe;
    localparam logic [7:0] ALT_PFX_1     = 8'hac;
    localparam logic [7:0] SVC_UUID_LO   = 8'haa;
    localparam logic [7:0] SVC_UUID_HI   = 8'hfe;
    localparam logic [7:0] FRAME_UID     = 8'h00;
    localparam logic [7:0] FRAME_URL     = 8'h10;
    localparam logic [7:0] FRAME_TLM     = 8'h20;

    localparam logic [7:0] NEED_APL = 8'd26;
    localparam logic [7:0] NEED_ALT = 8'd27;
    localparam logic [7:0] NEED_UID = 8'd21;
    localparam logic [7:0] NEED_URL = 8'd6;
    localparam logic [7:0] NEED_TLM = 8'd17;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        kind_t              frame_kind;
        logic [63:0]        id_word_a;
        logic [63:0]        id_word_b;
        logic [31:0]        id_word_c;
        logic [4:0]         id_length;
        logic [15:0]        word_one;
        logic [15:0]        word_two;
        logic signed [7:0]  power_level;
        logic [7:0]         aux_byte;
        logic [31:0]        packet_count;
        logic [31:0]        uptime_count;
    } result_t;

endpackage

/* rtl/bbap_in_reg.sv */
// Input register of the beacon parser: holds one byte request until the
// parse stage takes it. Depends on bbap_pkg.
module bbap_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             advance,
    output logic             item_valid,
    output bbap_pkg::item_t  item
);

    logic            valid_reg;
    bbap_pkg::item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= last_byte;
        end
    end

endmodule

/* rtl/bbap_parse.sv */
// Parse stage: walks length-type structures, matches the beacon formats and
// captures their fields; builds the result for the last byte. Uses bbap_pkg.
module bbap_parse
#(
    parameter int ID_BYTES = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  bbap_pkg::item_t    item,
    output bbap_pkg::result_t  result
);

    localparam int CNT_W = $clog2(ID_BYTES + 1);
    localparam int IDX_W = $clog2(ID_BYTES);
    localparam logic [7:0] ID_BYTES8 = 8'(ID_BYTES);

    logic [7:0]          offset_reg, length_reg;
    bbap_pkg::kind_t     kind_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [15:0]         w1_reg, w2_reg;
    logic [7:0]          power_reg, aux_reg, prefix_reg;
    logic [31:0]         pkts_reg, up_reg;
    bbap_pkg::path_t     path_reg;
    logic [7:0]          store_reg [ID_BYTES];

    logic [7:0]          offset_next, length_next;
    bbap_pkg::kind_t     kind_next;
    logic                done_next;
    logic [CNT_W-1:0]    count_next;
    logic [15:0]         w1_next, w2_next;
    logic [7:0]          power_next, aux_next, prefix_next;
    logic [31:0]         pkts_next, up_next;
    bbap_pkg::path_t     path_next;

    logic                wr_en, wr_ok;
    logic [7:0]          wr_idx, url_len, b, o;
    logic [7:0]          idv [bbap_pkg::OUT_ID_BYTES];
    logic [8*bbap_pkg::OUT_ID_BYTES-1:0] id_flat;
    bbap_pkg::kind_t     k;

    assign b     = item.data;
    assign o     = offset_reg;
    assign wr_ok = wr_en && (wr_idx < ID_BYTES8);
    assign url_len = length_reg - bbap_pkg::NEED_URL;

    always_comb
    begin
        offset_next = offset_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        done_next   = done_reg;
        count_next  = count_reg;
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        power_next  = power_reg;
        aux_next    = aux_reg;
        prefix_next = prefix_reg;
        pkts_next   = pkts_reg;
        up_next     = up_reg;
        path_next   = path_reg;
        wr_en       = 1'b0;
        wr_idx      = o - 8'd6;

        if (offset_reg == 8'd0)
        begin
            length_next = b;
            if (b != 8'd0)
            begin
                offset_next = 8'd1;
            end
        end
        else
        begin
            if (kind_reg == bbap_pkg::KIND_NONE)
            begin
                if (o == 8'd1)
                begin
                    if (b == bbap_pkg::AD_TYPE_MFR)
                        path_next = bbap_pkg::PATH_MFR;
                    else if (b == bbap_pkg::AD_TYPE_SVC)
                        path_next = bbap_pkg::PATH_SVC;
                    else
                        path_next = bbap_pkg::PATH_DEAD;
                end
                else if (path_reg == bbap_pkg::PATH_MFR)
                begin
                    if (o == 8'd2)
                        w1_next = {8'h00, b};
                    else if (o == 8'd3)
                        w1_next = w1_reg | {b, 8'h00};
                    else if (o == 8'd4)
                        prefix_next = b;
                    else if (o == 8'd5)
                    begin
                        if (w1_reg == {8'h00, bbap_pkg::CO_APL_LO}
                            && prefix_reg == bbap_pkg::APL_PFX_0
                            && b == bbap_pkg::APL_PFX_1)
                        begin
                            if (length_reg >= bbap_pkg::NEED_APL)
                            begin
                                kind_next  = bbap_pkg::KIND_APL;
                                count_next = CNT_W'(16);
                            end
                        end
                        else if (prefix_reg == bbap_pkg::ALT_PFX_0
                                 && b == bbap_pkg::ALT_PFX_1)
                        begin
                            if (length_reg >= bbap_pkg::NEED_ALT)
                            begin
                                kind_next  = bbap_pkg::KIND_ALT;
                                count_next = CNT_W'(20);
                            end
                        end
                        path_next = bbap_pkg::PATH_DEAD;
                    end
                end
                else if (path_reg == bbap_pkg::PATH_SVC)
                begin
                    if (o == 8'd2)
                    begin
                        if (b != bbap_pkg::SVC_UUID_LO)
                            path_next = bbap_pkg::PATH_DEAD;
                    end
                    else if (o == 8'd3)
                    begin
                        if (b != bbap_pkg::SVC_UUID_HI)
                            path_next = bbap_pkg::PATH_DEAD;
                    end
                    else if (o == 8'd4)
                    begin
                        if (b == bbap_pkg::FRAME_UID && length_reg >= bbap_pkg::NEED_UID)
                        begin
                            kind_next  = bbap_pkg::KIND_UID;
                            count_next = CNT_W'(16);
                        end
                        else if (b == bbap_pkg::FRAME_URL
                                 && length_reg >= bbap_pkg::NEED_URL)
                        begin
                            kind_next  = bbap_pkg::KIND_URL;
                            count_next = (url_len > ID_BYTES8) ? CNT_W'(ID_BYTES)
                                                               : CNT_W'(url_len);
                        end
                        else if (b == bbap_pkg::FRAME_TLM
                                 && length_reg >= bbap_pkg::NEED_TLM)
                        begin
                            kind_next  = bbap_pkg::KIND_TLM;
                            count_next = '0;
                        end
                        path_next = bbap_pkg::PATH_DEAD;
                    end
                end
            end
            else if (!done_reg)
            begin
                case (kind_reg)
                    bbap_pkg::KIND_APL:
                    begin
                        if (o inside {[8'd6:8'd21]})
                            wr_en = 1'b1;
                        else if (o == 8'd22)
                            w1_next = {b, 8'h00};
                        else if (o == 8'd23)
                            w1_next = w1_reg | {8'h00, b};
                        else if (o == 8'd24)
                            w2_next = {b, 8'h00};
                        else if (o == 8'd25)
                            w2_next = w2_reg | {8'h00, b};
                        else if (o == 8'd26)
                        begin
                            power_next = b;
                            done_next  = 1'b1;
                        end
                    end
                    bbap_pkg::KIND_ALT:
                    begin
                        if (o inside {[8'd6:8'd25]})
                            wr_en = 1'b1;
                        else if (o == 8'd26)
                            power_next = b;
                        else if (o == 8'd27)
                        begin
                            aux_next  = b;
                            done_next = 1'b1;
                        end
                    end
                    bbap_pkg::KIND_UID:
                    begin
                        if (o == 8'd5)
                            power_next = b;
                        else if (o inside {[8'd6:8'd21]})
                        begin
                            wr_en = 1'b1;
                            if (o == 8'd21)
                                done_next = 1'b1;
                        end
                    end
                    bbap_pkg::KIND_URL:
                    begin
                        if (o == 8'd5)
                            power_next = b;
                        else if (o == 8'd6)
                        begin
                            aux_next = b;
                            if (count_reg == '0)
                                done_next = 1'b1;
                        end
                        else if (o >= 8'd7)
                        begin
                            wr_en  = 1'b1;
                            wr_idx = o - 8'd7;
                            if ((o - 8'd6) >= 8'(count_reg))
                                done_next = 1'b1;
                        end
                    end
                    bbap_pkg::KIND_TLM:
                    begin
                        if (o == 8'd5)
                            aux_next = b;
                        else if (o inside {[8'd6:8'd7]})
                            w1_next = {w1_reg[7:0], b};
                        else if (o inside {[8'd8:8'd9]})
                            w2_next = {w2_reg[7:0], b};
                        else if (o inside {[8'd10:8'd13]})
                            pkts_next = {pkts_reg[23:0], b};
                        else if (o inside {[8'd14:8'd17]})
                        begin
                            up_next = {up_reg[23:0], b};
                            if (o == 8'd17)
                                done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (o >= length_reg)
                offset_next = 8'd0;
            else
                offset_next = o + 8'd1;
        end
    end

    for (genvar gi = 0; gi < bbap_pkg::OUT_ID_BYTES; gi++)
    begin : g_idv
        if (gi < ID_BYTES)
        begin : g_store
            assign idv[gi] = (wr_ok && wr_idx == 8'(gi)) ? b : store_reg[gi];
        end
        else
        begin : g_zero
            assign idv[gi] = 8'h00;
        end
    end

    always_comb
    begin
        k = done_next ? kind_next : bbap_pkg::KIND_NONE;
        for (int i = 0; i < bbap_pkg::OUT_ID_BYTES; i++)
        begin
            id_flat[8*(bbap_pkg::OUT_ID_BYTES-1-i) +: 8] =
                (CNT_W'(i) < count_next) ? idv[i] : 8'h00;
        end

        result = '0;
        result.frame_kind = k;
        if (k inside {bbap_pkg::KIND_APL, bbap_pkg::KIND_ALT, bbap_pkg::KIND_UID,
                      bbap_pkg::KIND_URL})
        begin
            result.id_word_a   = id_flat[159:96];
            result.id_word_b   = id_flat[95:32];
            result.id_word_c   = id_flat[31:0];
            result.id_length   = 5'(count_next);
            result.power_level = power_next;
        end
        if (k inside {bbap_pkg::KIND_APL, bbap_pkg::KIND_ALT, bbap_pkg::KIND_TLM})
            result.word_one = w1_next;
        if (k inside {bbap_pkg::KIND_APL, bbap_pkg::KIND_TLM})
            result.word_two = w2_next;
        if (k inside {bbap_pkg::KIND_ALT, bbap_pkg::KIND_URL, bbap_pkg::KIND_TLM})
            result.aux_byte = aux_next;
        if (k == bbap_pkg::KIND_TLM)
        begin
            result.packet_count = pkts_next;
            result.uptime_count = up_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            length_reg <= '0;
            kind_reg   <= bbap_pkg::KIND_NONE;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            w1_reg     <= '0;
            w2_reg     <= '0;
            power_reg  <= '0;
            aux_reg    <= '0;
            prefix_reg <= '0;
            pkts_reg   <= '0;
            up_reg     <= '0;
            path_reg   <= bbap_pkg::PATH_DEAD;
        end
        else if (advance)
        begin
            if (item.last)
            begin
                offset_reg <= '0;
                length_reg <= '0;
                kind_reg   <= bbap_pkg::KIND_NONE;
                done_reg   <= 1'b0;
                count_reg  <= '0;
                w1_reg     <= '0;
                w2_reg     <= '0;
                power_reg  <= '0;
                aux_reg    <= '0;
                prefix_reg <= '0;
                pkts_reg   <= '0;
                up_reg     <= '0;
                path_reg   <= bbap_pkg::PATH_DEAD;
            end
            else
            begin
                offset_reg <= offset_next;
                length_reg <= length_next;
                kind_reg   <= kind_next;
                done_reg   <= done_next;
                count_reg  <= count_next;
                w1_reg     <= w1_next;
                w2_reg     <= w2_next;
                power_reg  <= power_next;
                aux_reg    <= aux_next;
                prefix_reg <= prefix_next;
                pkts_reg   <= pkts_next;
                up_reg     <= up_next;
                path_reg   <= path_next;
            end
        end
    end

    // id bytes past the valid count are masked on output, so no clear needed
    always_ff @(posedge clk)
    begin
        if (advance && wr_ok)
        begin
            store_reg[wr_idx[IDX_W-1:0]] <= b;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last |=> offset_reg == 8'd0 && kind_reg == bbap_pkg::KIND_NONE
                                 && !done_reg)
        else $error("parser state not cleared after last byte");

    a_done_needs_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> kind_reg != bbap_pkg::KIND_NONE)
        else $error("capture complete without a matched format");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg == bbap_pkg::KIND_URL |-> count_reg <= CNT_W'(ID_BYTES))
        else $error("url body count above store depth");

endmodule

/* rtl/bbap_out_reg.sv */
// Result register of the beacon parser: holds one result request until the
// downstream side takes it. Depends on bbap_pkg.
module bbap_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bbap_pkg::result_t  res_in,
    input  logic               out_stall,
    output logic               out_valid,
    output bbap_pkg::result_t  res_out
);

    logic              valid_reg;
    bbap_pkg::result_t res_reg;

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

/* rtl/ble_beacon_advert_parser.sv */
// Advertising beacon parser: takes one payload byte per cycle unless in_stall
// is high; each byte flagged last gives one result in the result register.
// The input stalls only while a last byte sits in the input register and the
// result register still holds an untaken result. Uses bbap_pkg and submodules.
module ble_beacon_advert_parser
#(
    parameter int ID_BYTES = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         frame_kind,
    output logic [63:0]        id_word_a,
    output logic [63:0]        id_word_b,
    output logic [31:0]        id_word_c,
    output logic [4:0]         id_length,
    output logic [15:0]        word_one,
    output logic [15:0]        word_two,
    output logic signed [7:0]  power_level,
    output logic [7:0]         aux_byte,
    output logic [31:0]        packet_count,
    output logic [31:0]        uptime_count
);

    logic              item_valid, advance;
    bbap_pkg::item_t   item;
    bbap_pkg::result_t res_next, res;

    assign advance = item_valid && (!item.last || !out_valid || !out_stall);

    bbap_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bbap_parse #(.ID_BYTES(ID_BYTES)) u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (res_next)
    );

    bbap_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && item.last),
        .res_in    (res_next),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_out   (res)
    );

    assign frame_kind   = 3'(res.frame_kind);
    assign id_word_a    = res.id_word_a;
    assign id_word_b    = res.id_word_b;
    assign id_word_c    = res.id_word_c;
    assign id_length    = res.id_length;
    assign word_one     = res.word_one;
    assign word_two     = res.word_two;
    assign power_level  = res.power_level;
    assign aux_byte     = res.aux_byte;
    assign packet_count = res.packet_count;
    assign uptime_count = res.uptime_count;

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == 3'(bbap_pkg::KIND_NONE) |->
            id_word_a == '0 && id_length == '0 && word_one == '0 && packet_count == '0)
        else $error("empty result carries field data");

    a_tlm_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == 3'(bbap_pkg::KIND_TLM) |->
            id_length == '0 && power_level == '0 && id_word_a == '0)
        else $error("telemetry result carries id data");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid && item.last && out_valid)
        else $error("input stalled without a pending last byte");

endmodule

/* tb/sv/ble_beacon_advert_parser_test.sv */
// Self-checking testbench for ble_beacon_advert_parser: byte-stream stimulus,
// a built-in beacon decoder for expected results, and field-by-field checking.
// Depends on bbap_pkg and the ble_beacon_advert_parser RTL.
module ble_beacon_advert_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_N       = bbap_pkg::OUT_ID_BYTES;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               last_byte = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         frame_kind;
    logic [63:0]        id_word_a;
    logic [63:0]        id_word_b;
    logic [31:0]        id_word_c;
    logic [4:0]         id_length;
    logic [15:0]        word_one;
    logic [15:0]        word_two;
    logic signed [7:0]  power_level;
    logic [7:0]         aux_byte;
    logic [31:0]        packet_count;
    logic [31:0]        uptime_count;

    ble_beacon_advert_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_kind   (frame_kind),
        .id_word_a    (id_word_a),
        .id_word_b    (id_word_b),
        .id_word_c    (id_word_c),
        .id_length    (id_length),
        .word_one     (word_one),
        .word_two     (word_two),
        .power_level  (power_level),
        .aux_byte     (aux_byte),
        .packet_count (packet_count),
        .uptime_count (uptime_count)
    );

    always #6 clk = ~clk;

    // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int idle_mode = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int kind_hits[6];

    bbap_pkg::result_t beacon_q[$];
    logic [7:0] pdu[$];

    // decoder state
    logic [7:0]        ps_off;
    logic [7:0]        ps_len;
    bbap_pkg::kind_t   ps_kind;
    logic              ps_done;
    logic [7:0]        ps_id[ID_N];
    logic [7:0]        ps_count;
    logic [15:0]       ps_w1;
    logic [15:0]       ps_w2;
    logic [7:0]        ps_pow;
    logic [7:0]        ps_aux;
    logic [31:0]       ps_pkts;
    logic [31:0]       ps_up;
    bbap_pkg::path_t   ps_path;
    logic [7:0]        ps_pfx;

    task automatic decoder_clear();
        ps_off = '0;
        ps_len = '0;
        ps_kind = bbap_pkg::KIND_NONE;
        ps_done = 1'b0;
        for (int i = 0; i < ID_N; i++) ps_id[i] = '0;
        ps_count = '0;
        ps_w1 = '0;
        ps_w2 = '0;
        ps_pow = '0;
        ps_aux = '0;
        ps_pkts = '0;
        ps_up = '0;
        ps_path = bbap_pkg::PATH_DEAD;
        ps_pfx = '0;
    endtask

    task automatic put_id(input int idx, input logic [7:0] b);
        if (idx < ID_N) ps_id[idx] = b;
    endtask

    function automatic logic [7:0] id_at(input int idx);
        if (idx < ID_N && idx < int'(ps_count)) return ps_id[idx];
        return 8'h00;
    endfunction

    function automatic int need_of(input bbap_pkg::kind_t k);
        case (k)
            bbap_pkg::KIND_APL: return int'(bbap_pkg::NEED_APL);
            bbap_pkg::KIND_ALT: return int'(bbap_pkg::NEED_ALT);
            bbap_pkg::KIND_UID: return int'(bbap_pkg::NEED_UID);
            bbap_pkg::KIND_URL: return int'(bbap_pkg::NEED_URL);
            default:            return int'(bbap_pkg::NEED_TLM);
        endcase
    endfunction

    task automatic match_header(input int o, input logic [7:0] b);
        bbap_pkg::kind_t k;
        int need;
        int body;
        k = bbap_pkg::KIND_NONE;
        need = 0;
        if (o == 1)
        begin
            if (b == bbap_pkg::AD_TYPE_MFR) ps_path = bbap_pkg::PATH_MFR;
            else if (b == bbap_pkg::AD_TYPE_SVC) ps_path = bbap_pkg::PATH_SVC;
            else ps_path = bbap_pkg::PATH_DEAD;
        end
        else if (ps_path == bbap_pkg::PATH_MFR)
        begin
            case (o)
                2: ps_w1 = {8'h00, b};
                3: ps_w1 = ps_w1 | {b, 8'h00};
                4: ps_pfx = b;
                5:
                begin
                    if (ps_w1 == {8'h00, bbap_pkg::CO_APL_LO} && ps_pfx == bbap_pkg::APL_PFX_0
                        && b == bbap_pkg::APL_PFX_1)
                    begin
                        k = bbap_pkg::KIND_APL;
                    end
                    else if (ps_pfx == bbap_pkg::ALT_PFX_0 && b == bbap_pkg::ALT_PFX_1)
                    begin
                        k = bbap_pkg::KIND_ALT;
                    end
                    if (k != bbap_pkg::KIND_NONE) need = need_of(k);
                    if (k != bbap_pkg::KIND_NONE && int'(ps_len) >= need)
                    begin
                        ps_kind = k;
                        ps_count = (k == bbap_pkg::KIND_APL) ? 8'd16 : 8'd20;
                    end
                    ps_path = bbap_pkg::PATH_DEAD;
                end
                default: ;
            endcase
        end
        else if (ps_path == bbap_pkg::PATH_SVC)
        begin
            if (o == 2)
            begin
                if (b != bbap_pkg::SVC_UUID_LO) ps_path = bbap_pkg::PATH_DEAD;
            end
            else if (o == 3)
            begin
                if (b != bbap_pkg::SVC_UUID_HI) ps_path = bbap_pkg::PATH_DEAD;
            end
            else if (o == 4)
            begin
                if (b == bbap_pkg::FRAME_UID) k = bbap_pkg::KIND_UID;
                else if (b == bbap_pkg::FRAME_URL) k = bbap_pkg::KIND_URL;
                else if (b == bbap_pkg::FRAME_TLM) k = bbap_pkg::KIND_TLM;
                if (k != bbap_pkg::KIND_NONE) need = need_of(k);
                if (k != bbap_pkg::KIND_NONE && int'(ps_len) >= need)
                begin
                    ps_kind = k;
                    if (k == bbap_pkg::KIND_UID) ps_count = 8'd16;
                    else if (k == bbap_pkg::KIND_URL)
                    begin
                        body = int'(ps_len) - 6;
                        ps_count = (body > ID_N) ? 8'(ID_N) : 8'(body);
                    end
                    else ps_count = 8'd0;
                end
                ps_path = bbap_pkg::PATH_DEAD;
            end
        end
    endtask

    task automatic capture_field(input int o, input logic [7:0] b);
        case (ps_kind)
            bbap_pkg::KIND_APL:
            begin
                if (o inside {[6:21]}) put_id(o - 6, b);
                else if (o == 22) ps_w1 = {b, 8'h00};
                else if (o == 23) ps_w1 = ps_w1 | {8'h00, b};
                else if (o == 24) ps_w2 = {b, 8'h00};
                else if (o == 25) ps_w2 = ps_w2 | {8'h00, b};
                else if (o == 26)
                begin
                    ps_pow = b;
                    ps_done = 1'b1;
                end
            end
            bbap_pkg::KIND_ALT:
            begin
                if (o inside {[6:25]}) put_id(o - 6, b);
                else if (o == 26) ps_pow = b;
                else if (o == 27)
                begin
                    ps_aux = b;
                    ps_done = 1'b1;
                end
            end
            bbap_pkg::KIND_UID:
            begin
                if (o == 5) ps_pow = b;
                else if (o inside {[6:21]})
                begin
                    put_id(o - 6, b);
                    if (o == 21) ps_done = 1'b1;
                end
            end
            bbap_pkg::KIND_URL:
            begin
                if (o == 5) ps_pow = b;
                else if (o == 6)
                begin
                    ps_aux = b;
                    if (ps_count == 8'd0) ps_done = 1'b1;
                end
                else if (o >= 7)
                begin
                    put_id(o - 7, b);
                    if (o - 6 >= int'(ps_count)) ps_done = 1'b1;
                end
            end
            bbap_pkg::KIND_TLM:
            begin
                if (o == 5) ps_aux = b;
                else if (o inside {[6:7]}) ps_w1 = {ps_w1[7:0], b};
                else if (o inside {[8:9]}) ps_w2 = {ps_w2[7:0], b};
                else if (o inside {[10:13]}) ps_pkts = {ps_pkts[23:0], b};
                else if (o inside {[14:17]})
                begin
                    ps_up = {ps_up[23:0], b};
                    if (o == 17) ps_done = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic l);
        int o;
        bbap_pkg::kind_t k;
        bbap_pkg::result_t r;
        if (ps_off == 8'd0)
        begin
            ps_len = b;
            if (b != 8'd0) ps_off = 8'd1;
        end
        else
        begin
            o = int'(ps_off);
            if (ps_kind == bbap_pkg::KIND_NONE) match_header(o, b);
            else if (!ps_done) capture_field(o, b);
            if (o >= int'(ps_len)) ps_off = 8'd0;
            else ps_off = 8'(o + 1);
        end
        if (l)
        begin
            r = '0;
            k = ps_done ? ps_kind : bbap_pkg::KIND_NONE;
            if (k != bbap_pkg::KIND_NONE)
            begin
                r.frame_kind = k;
                if (k inside {bbap_pkg::KIND_APL, bbap_pkg::KIND_ALT, bbap_pkg::KIND_UID,
                              bbap_pkg::KIND_URL})
                begin
                    for (int i = 0; i < 8; i++) r.id_word_a = {r.id_word_a[55:0], id_at(i)};
                    for (int i = 8; i < 16; i++) r.id_word_b = {r.id_word_b[55:0], id_at(i)};
                    for (int i = 16; i < 20; i++) r.id_word_c = {r.id_word_c[23:0], id_at(i)};
                    r.id_length = ps_count[4:0];
                    r.power_level = ps_pow;
                end
                if (k inside {bbap_pkg::KIND_APL, bbap_pkg::KIND_ALT, bbap_pkg::KIND_TLM})
                    r.word_one = ps_w1;
                if (k inside {bbap_pkg::KIND_APL, bbap_pkg::KIND_TLM})
                    r.word_two = ps_w2;
                if (k inside {bbap_pkg::KIND_ALT, bbap_pkg::KIND_URL, bbap_pkg::KIND_TLM})
                    r.aux_byte = ps_aux;
                if (k == bbap_pkg::KIND_TLM)
                begin
                    r.packet_count = ps_pkts;
                    r.uptime_count = ps_up;
                end
            end
            kind_hits[r.frame_kind]++;
            beacon_q.push_back(r);
            decoder_clear();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) decode_byte(data_byte, last_byte);
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        bbap_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (beacon_q.size() == 0)
            begin
                mismatches++;
                $error("result with no pending request, frame_kind %0d", frame_kind);
            end
            else
            begin
                want = beacon_q.pop_front();
                check_field("frame_kind", 64'(want.frame_kind), 64'(frame_kind));
                check_field("id_word_a", want.id_word_a, id_word_a);
                check_field("id_word_b", want.id_word_b, id_word_b);
                check_field("id_word_c", 64'(want.id_word_c), 64'(id_word_c));
                check_field("id_length", 64'(want.id_length), 64'(id_length));
                check_field("word_one", 64'(want.word_one), 64'(word_one));
                check_field("word_two", 64'(want.word_two), 64'(word_two));
                check_field("power_level", 64'(want.power_level), 64'(power_level));
                check_field("aux_byte", 64'(want.aux_byte), 64'(aux_byte));
                check_field("packet_count", 64'(want.packet_count), 64'(packet_count));
                check_field("uptime_count", 64'(want.uptime_count), 64'(uptime_count));
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < ((idle_mode == 2) ? 55 : (idle_mode == 3) ? 21 : 0));
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < ((idle_mode == 1) ? 55 : (idle_mode == 3) ? 21 : 0))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // sends the built payload, optionally only its first upto bytes
    task automatic send_pdu(input int upto);
        int n;
        n = pdu.size();
        if (upto > 0 && upto < n) n = upto;
        for (int i = 0; i < n; i++) send_byte(pdu[i], i == n - 1);
        pdu.delete();
    endtask

    // fill < 0 gives random body bytes
    task automatic add_struct(input int len, input logic [39:0] hdr, input int hdr_n,
                              input int fill);
        pdu.push_back(8'(len));
        for (int i = 0; i < len; i++)
        begin
            if (i < hdr_n) pdu.push_back(hdr[39 - 8 * i -: 8]);
            else if (fill < 0) pdu.push_back(8'($urandom));
            else pdu.push_back(8'(fill));
        end
    endtask

    task automatic add_beacon(input bbap_pkg::kind_t k, input int len, input int fill,
                              input bit broken);
        logic [39:0] hdr;
        int n;
        n = 4;
        case (k)
            bbap_pkg::KIND_APL:
            begin
                hdr = {bbap_pkg::AD_TYPE_MFR, bbap_pkg::CO_APL_LO, 8'h00,
                       bbap_pkg::APL_PFX_0, bbap_pkg::APL_PFX_1};
                n = 5;
            end
            bbap_pkg::KIND_ALT:
            begin
                hdr = {bbap_pkg::AD_TYPE_MFR, 8'($urandom), 8'($urandom),
                       bbap_pkg::ALT_PFX_0, bbap_pkg::ALT_PFX_1};
                n = 5;
            end
            bbap_pkg::KIND_UID:
                hdr = {bbap_pkg::AD_TYPE_SVC, bbap_pkg::SVC_UUID_LO, bbap_pkg::SVC_UUID_HI,
                       bbap_pkg::FRAME_UID, 8'h00};
            bbap_pkg::KIND_URL:
                hdr = {bbap_pkg::AD_TYPE_SVC, bbap_pkg::SVC_UUID_LO, bbap_pkg::SVC_UUID_HI,
                       bbap_pkg::FRAME_URL, 8'h00};
            default:
                hdr = {bbap_pkg::AD_TYPE_SVC, bbap_pkg::SVC_UUID_LO, bbap_pkg::SVC_UUID_HI,
                       bbap_pkg::FRAME_TLM, 8'h00};
        endcase
        if (broken) hdr[40 - 8 * n + $urandom_range(8 * n - 1)] ^= 1'b1;
        add_struct(len, hdr, n, fill);
    endtask

    task automatic test_each_format();
        add_beacon(bbap_pkg::KIND_APL, need_of(bbap_pkg::KIND_APL), 255, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_ALT, need_of(bbap_pkg::KIND_ALT), -1, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_UID, need_of(bbap_pkg::KIND_UID), 0, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_URL, need_of(bbap_pkg::KIND_URL), -1, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_URL, 14, -1, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_TLM, need_of(bbap_pkg::KIND_TLM), 255, 1'b0);
        send_pdu(-1);
    endtask

    task automatic test_zero_and_short();
        pdu.push_back(8'h00);
        pdu.push_back(8'h00);
        add_beacon(bbap_pkg::KIND_APL, need_of(bbap_pkg::KIND_APL), -1, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_APL, need_of(bbap_pkg::KIND_APL) - 1, -1, 1'b0);
        add_beacon(bbap_pkg::KIND_UID, need_of(bbap_pkg::KIND_UID) + 2, -1, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_URL, need_of(bbap_pkg::KIND_URL) - 1, -1, 1'b0);
        add_beacon(bbap_pkg::KIND_TLM, need_of(bbap_pkg::KIND_TLM) + 3, -1, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_ALT, need_of(bbap_pkg::KIND_ALT) - 1, -1, 1'b0);
        pdu.push_back(8'h00);
        send_pdu(-1);
    endtask

    task automatic test_unknown_and_cut();
        add_struct(4, {8'h09, 32'h0}, 1, -1);
        add_beacon(bbap_pkg::KIND_URL, 12, -1, 1'b0);
        send_pdu(-1);
        add_struct(10, {bbap_pkg::AD_TYPE_SVC, bbap_pkg::SVC_UUID_LO, 8'h00,
                        bbap_pkg::FRAME_UID, 8'h00}, 4, -1);
        add_struct(8, {bbap_pkg::AD_TYPE_SVC, bbap_pkg::SVC_UUID_LO, bbap_pkg::SVC_UUID_HI,
                       8'h30, 8'h00}, 4, -1);
        add_struct(30, {bbap_pkg::AD_TYPE_MFR, bbap_pkg::CO_APL_LO, 8'h00,
                        bbap_pkg::APL_PFX_0, 8'h16}, 5, -1);
        send_pdu(-1);
        // payload ends inside the capture
        add_beacon(bbap_pkg::KIND_APL, need_of(bbap_pkg::KIND_APL), -1, 1'b0);
        send_pdu(15);
        // payload ends on a length byte
        add_beacon(bbap_pkg::KIND_TLM, need_of(bbap_pkg::KIND_TLM), -1, 1'b0);
        pdu.push_back(8'h05);
        send_pdu(-1);
        add_struct(12, {40'h0}, 0, -1);
        send_pdu(6);
        // later structures after a finished capture are ignored
        add_beacon(bbap_pkg::KIND_UID, need_of(bbap_pkg::KIND_UID), -1, 1'b0);
        add_beacon(bbap_pkg::KIND_APL, need_of(bbap_pkg::KIND_APL), -1, 1'b0);
        pdu.push_back(8'h03);
        send_pdu(-1);
        pdu.push_back(8'h00);
        send_pdu(-1);
        pdu.push_back(8'hff);
        send_pdu(-1);
    endtask

    task automatic test_url_limits();
        add_beacon(bbap_pkg::KIND_URL, 26, -1, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_URL, 30, 255, 1'b0);
        send_pdu(-1);
        add_beacon(bbap_pkg::KIND_URL, 255, -1, 1'b0);
        send_pdu(-1);
    endtask

    task automatic random_payload();
        int pick;
        int len;
        bbap_pkg::kind_t k;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 4)) pdu.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                pick = $urandom_range(99);
                k = bbap_pkg::kind_t'($urandom_range(1, 5));
                if (pick < 55)
                begin
                    if (k == bbap_pkg::KIND_URL) len = $urandom_range(6, 30);
                    else if ($urandom_range(3) == 0) len = need_of(k) + $urandom_range(1, 8);
                    else len = need_of(k);
                    add_beacon(k, len, -1, 1'b0);
                end
                else if (pick < 65)
                    add_beacon(k, need_of(k) - $urandom_range(1, 3), -1, 1'b0);
                else if (pick < 75)
                    pdu.push_back(8'h00);
                else if (pick < 90)
                    add_struct($urandom_range(1, 12), {$urandom, 8'($urandom)}, 5, -1);
                else
                    add_beacon(k, need_of(k) + $urandom_range(0, 3), -1, 1'b1);
            end
        end
        if ($urandom_range(99) < 15) send_pdu($urandom_range(1, pdu.size()));
        else send_pdu(-1);
    endtask

    task automatic test_random_traffic(input int total);
        int start;
        for (int m = 0; m < 4; m++)
        begin
            idle_mode = m;
            start = bytes_sent;
            while (bytes_sent - start < total / 4) random_payload();
        end
        idle_mode = 0;
    endtask

    initial
    begin
        decoder_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_each_format();
        test_zero_and_short();
        test_unknown_and_cut();
        test_url_limits();
        test_random_traffic(800);
        in_valid <= 1'b0;
        while (beacon_q.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        $display("%0d payload bytes, %0d results checked, four idle/stall profiles",
                 bytes_sent, results_seen);
        $display("kinds: none %0d, apl %0d, alt %0d, uid %0d, url %0d, tlm %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
                 kind_hits[4], kind_hits[5]);
        if (mismatches == 0 && beacon_q.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
